>>> design/ftqpf_pkg.sv
// shared types and constants of the fetch target queue with partial flush
// no dependencies
package ftqpf_pkg;

    localparam int QUEUE_DEPTH_DEF    = 128;
    localparam int OPS_PER_TARGET_DEF = 16;

    localparam int PC_W  = 48;
    localparam int TAG_W = 32;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_ADD     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_CONSUME = 3'd3,
        OP_FLUSH   = 3'd4,
        OP_PFLUSH  = 3'd5
    } t_opcode;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_OVERWR  = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_PK_META,
        S_PK_RD,
        S_PK_OUT,
        S_PF_META,
        S_PF_MRES,
        S_PF_RD,
        S_PF_CHK,
        S_PF_WMETA,
        S_PF_NEXT,
        S_RESP
    } t_state;

endpackage

>>> design/fetch_target_queue_partial_flush_top.sv
// Start, consume, flush and ignored requests go straight to the result word; add reads
// the newest target's metadata first; peek reads head metadata, then each op word in turn;
// partial flush reads each target's metadata, then its stored ops via the op read port.
// One request is worked at a time; a new one is taken once the last word is registered.
// Reset: synchronous active low, empties the ring and sets enable; per-target valid flops
// stand in for cleared metadata. Depends on ftqpf_pkg and ftqpf_ram.
module fetch_target_queue_partial_flush_top #(
    parameter int QUEUE_DEPTH    = ftqpf_pkg::QUEUE_DEPTH_DEF,
    parameter int OPS_PER_TARGET = ftqpf_pkg::OPS_PER_TARGET_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_opcode,
    input  logic [ftqpf_pkg::PC_W-1:0] i_op_pc,
    input  logic [ftqpf_pkg::TAG_W-1:0] i_op_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_status,
    output logic [7:0]                 o_entry_count,
    output logic [ftqpf_pkg::PC_W-1:0] o_head_start_pc,
    output logic [ftqpf_pkg::PC_W-1:0] o_head_end_pc,
    output logic [4:0]                 o_head_ops,
    output logic [3:0]                 o_out_slot,
    output logic [ftqpf_pkg::PC_W-1:0] o_out_pc,
    output logic [ftqpf_pkg::TAG_W-1:0] o_out_tag,
    output logic                       o_last
);

    import ftqpf_pkg::*;

    localparam int TW   = $clog2(QUEUE_DEPTH);
    localparam int OCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = $clog2(OPS_PER_TARGET + 1);
    localparam int ODEP = QUEUE_DEPTH * OPS_PER_TARGET;
    localparam int OW   = $clog2(ODEP);
    localparam int MW   = CW + 2 * PC_W;
    localparam int OPW  = PC_W + TAG_W;

    // control and ring state
    t_state               r_state, n_state;
    logic                 r_en, n_en;
    logic [TW-1:0]        r_head, n_head;
    logic [TW-1:0]        r_tail, n_tail;
    logic [OCW-1:0]       r_occ, n_occ;
    logic [QUEUE_DEPTH-1:0] r_tvalid, n_tvalid;

    // request and walk registers
    logic [PC_W-1:0]      r_pc, n_pc;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [2:0]           r_status, n_status;
    logic [TW-1:0]        r_t, n_t;
    logic [OCW-1:0]       r_k, n_k;
    logic [OCW-1:0]       r_keep, n_keep;
    logic                 r_rm, n_rm;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_w, n_w;
    logic [PC_W-1:0]      r_hs, n_hs;
    logic [PC_W-1:0]      r_he, n_he;

    // output register
    logic                 r_ovalid, n_ovalid;
    logic [2:0]           r_ostatus, n_ostatus;
    logic [7:0]           r_ocnt, n_ocnt;
    logic [PC_W-1:0]      r_ohs, n_ohs;
    logic [PC_W-1:0]      r_ohe, n_ohe;
    logic [4:0]           r_ohops, n_ohops;
    logic [3:0]           r_oslot, n_oslot;
    logic [PC_W-1:0]      r_opc, n_opc;
    logic [TAG_W-1:0]     r_otag, n_otag;
    logic                 r_olast, n_olast;

    // memory ports
    logic                 m_we, m_re;
    logic [TW-1:0]        m_waddr, m_raddr;
    logic [MW-1:0]        m_wdata, m_rdata;
    logic                 p_we, p_re;
    logic [OW-1:0]        p_waddr, p_raddr;
    logic [OPW-1:0]       p_wdata, p_rdata;

    // helpers
    logic                 out_free;
    logic                 accept;
    logic [TW-1:0]        tail_m1;
    logic                 m_valid;
    logic [CW-1:0]        m_cnt;
    logic [PC_W-1:0]      m_start, m_end;
    logic [OW-1:0]        base;
    logic [TW:0]          tail_sum;

    function automatic logic [TW-1:0] inc_t(input logic [TW-1:0] x);
        return (x == TW'(QUEUE_DEPTH - 1)) ? '0 : x + TW'(1);
    endfunction

    assign out_free = !r_ovalid || i_ready;
    assign accept   = (r_state == S_IDLE) && i_valid;
    assign o_ready  = (r_state == S_IDLE);
    assign tail_m1  = (r_tail == '0) ? TW'(QUEUE_DEPTH - 1) : r_tail - TW'(1);
    assign m_valid  = r_tvalid[r_t];
    assign m_cnt    = m_valid ? m_rdata[MW-1 -: CW] : '0;
    assign m_start  = m_valid ? m_rdata[2*PC_W-1 -: PC_W] : '0;
    assign m_end    = m_valid ? m_rdata[PC_W-1:0] : '0;
    assign base     = OW'(r_t) * OW'(OPS_PER_TARGET);
    assign tail_sum = {1'b0, r_head} + (TW+1)'(r_keep);

    // target metadata: op count, first and last pc
    ftqpf_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_meta (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // op store: pc and tag per slot
    ftqpf_ram #(.WIDTH(OPW), .DEPTH(ODEP)) u_ops (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_opcode)
                        OP_ADD:    n_state = (!r_en || r_occ == '0) ? S_RESP : S_ADD;
                        OP_PEEK:   n_state = (r_occ == '0) ? S_RESP : S_PK_META;
                        OP_PFLUSH: n_state = (r_occ == '0) ? S_RESP : S_PF_META;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_ADD:      n_state = S_RESP;
            S_PK_META:  n_state = (m_cnt == '0) ? S_RESP : S_PK_RD;
            S_PK_RD:    n_state = S_PK_OUT;
            S_PK_OUT: begin
                if (out_free) begin
                    n_state = (r_i + CW'(1) == r_n) ? S_IDLE : S_PK_RD;
                end
            end
            S_PF_META:  n_state = S_PF_MRES;
            S_PF_MRES:  n_state = (m_cnt == '0) ? S_PF_NEXT : S_PF_RD;
            S_PF_RD:    n_state = S_PF_CHK;
            S_PF_CHK:   n_state = (r_i + CW'(1) == r_n) ? S_PF_WMETA : S_PF_RD;
            S_PF_WMETA: n_state = S_PF_NEXT;
            S_PF_NEXT:  n_state = (r_k + OCW'(1) == r_occ) ? S_RESP : S_PF_META;
            S_RESP:     n_state = out_free ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_en      = r_en;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_tvalid  = r_tvalid;
        n_pc      = r_pc;
        n_tag     = r_tag;
        n_status  = r_status;
        n_t       = r_t;
        n_k       = r_k;
        n_keep    = r_keep;
        n_rm      = r_rm;
        n_n       = r_n;
        n_i       = r_i;
        n_w       = r_w;
        n_hs      = r_hs;
        n_he      = r_he;
        n_ovalid  = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_ocnt    = r_ocnt;
        n_ohs     = r_ohs;
        n_ohe     = r_ohe;
        n_ohops   = r_ohops;
        n_oslot   = r_oslot;
        n_opc     = r_opc;
        n_otag    = r_otag;
        n_olast   = r_olast;
        m_we      = 1'b0;
        m_waddr   = r_t;
        m_wdata   = {r_w, r_hs, r_he};
        m_re      = 1'b0;
        m_raddr   = r_t;
        p_we      = 1'b0;
        p_waddr   = base + OW'(r_w);
        p_wdata   = p_rdata;
        p_re      = 1'b0;
        p_raddr   = base + OW'(r_i);

        // configuration write
        if (i_cfg_we) begin
            n_en = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pc     = i_op_pc;
                    n_tag    = i_op_tag;
                    n_hs     = '0;
                    n_he     = '0;
                    n_status = ST_OK;
                    n_t      = r_head;
                    n_k      = '0;
                    n_keep   = '0;
                    n_rm     = 1'b0;
                    m_raddr  = r_head;
                    case (i_opcode)
                        OP_START: begin
                            if (!r_en) begin
                                n_status = ST_IGNORED;
                            end else begin
                                if (r_occ >= OCW'(QUEUE_DEPTH)) begin
                                    n_tvalid[r_head] = 1'b0;
                                    n_head           = inc_t(r_head);
                                    n_status         = ST_OVERWR;
                                end else begin
                                    n_occ = r_occ + OCW'(1);
                                end
                                n_tvalid[r_tail] = 1'b0;
                                n_tail           = inc_t(r_tail);
                            end
                        end
                        OP_ADD: begin
                            if (!r_en || r_occ == '0) begin
                                n_status = ST_IGNORED;
                            end else begin
                                n_t     = tail_m1;
                                m_raddr = tail_m1;
                                m_re    = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (r_occ == '0) begin
                                n_status = ST_IGNORED;
                            end else begin
                                m_re = 1'b1;
                            end
                        end
                        OP_CONSUME: begin
                            if (r_occ == '0) begin
                                n_status = ST_IGNORED;
                            end else begin
                                n_tvalid[r_head] = 1'b0;
                                n_head           = inc_t(r_head);
                                n_occ            = r_occ - OCW'(1);
                            end
                        end
                        OP_FLUSH: begin
                            n_tvalid = '0;
                            n_head   = '0;
                            n_tail   = '0;
                            n_occ    = '0;
                        end
                        OP_PFLUSH: begin
                            if (r_occ == '0) begin
                                n_status = ST_IGNORED;
                            end
                        end
                        default: n_status = ST_IGNORED;
                    endcase
                end
            end
            // append op to newest target
            S_ADD: begin
                if (m_cnt >= CW'(OPS_PER_TARGET)) begin
                    n_status = ST_DROPPED;
                end else begin
                    p_we          = 1'b1;
                    p_waddr       = base + OW'(m_cnt);
                    p_wdata       = {r_pc, r_tag};
                    m_we          = 1'b1;
                    m_wdata       = {m_cnt + CW'(1), (m_cnt == '0) ? r_pc : m_start, r_pc};
                    n_tvalid[r_t] = 1'b1;
                end
            end
            // peek: capture head metadata
            S_PK_META: begin
                n_n  = m_cnt;
                n_i  = '0;
                n_hs = m_start;
                n_he = m_end;
            end
            S_PK_RD: begin
                p_re = 1'b1;
            end
            S_PK_OUT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_OK;
                    n_ocnt    = 8'(r_occ);
                    n_ohs     = r_hs;
                    n_ohe     = r_he;
                    n_ohops   = 5'(r_n);
                    n_oslot   = 4'(r_i);
                    n_opc     = p_rdata[OPW-1 -: PC_W];
                    n_otag    = p_rdata[TAG_W-1:0];
                    n_olast   = (r_i + CW'(1) == r_n);
                    n_i       = r_i + CW'(1);
                end
            end
            // partial flush walk
            S_PF_META: begin
                m_re = 1'b1;
            end
            S_PF_MRES: begin
                n_n  = m_cnt;
                n_i  = '0;
                n_w  = '0;
                n_hs = m_start;
                n_he = m_end;
            end
            S_PF_RD: begin
                p_re = 1'b1;
            end
            S_PF_CHK: begin
                if (p_rdata[TAG_W-1:0] > r_tag) begin
                    n_rm = 1'b1;
                end else begin
                    p_we = 1'b1;
                    n_w  = r_w + CW'(1);
                end
                n_i = r_i + CW'(1);
            end
            S_PF_WMETA: begin
                m_we = 1'b1;
                if (r_w != '0) begin
                    n_keep = r_k + OCW'(1);
                end
            end
            S_PF_NEXT: begin
                n_k  = r_k + OCW'(1);
                n_t  = inc_t(r_t);
                n_hs = '0;
                n_he = '0;
                if (r_k + OCW'(1) == r_occ) begin
                    n_occ    = r_keep;
                    n_tail   = (tail_sum >= (TW+1)'(QUEUE_DEPTH)) ?
                               TW'(tail_sum - (TW+1)'(QUEUE_DEPTH)) : TW'(tail_sum);
                    n_status = r_rm ? ST_OK : ST_NONE;
                end
            end
            // single result word
            S_RESP: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ocnt    = 8'(r_occ);
                    n_ohs     = r_hs;
                    n_ohe     = r_he;
                    n_ohops   = '0;
                    n_oslot   = '0;
                    n_opc     = '0;
                    n_otag    = '0;
                    n_olast   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b1;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_tvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_en     <= n_en;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_occ    <= n_occ;
            r_tvalid <= n_tvalid;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pc      <= n_pc;
        r_tag     <= n_tag;
        r_status  <= n_status;
        r_t       <= n_t;
        r_k       <= n_k;
        r_keep    <= n_keep;
        r_rm      <= n_rm;
        r_n       <= n_n;
        r_i       <= n_i;
        r_w       <= n_w;
        r_hs      <= n_hs;
        r_he      <= n_he;
        r_ostatus <= n_ostatus;
        r_ocnt    <= n_ocnt;
        r_ohs     <= n_ohs;
        r_ohe     <= n_ohe;
        r_ohops   <= n_ohops;
        r_oslot   <= n_oslot;
        r_opc     <= n_opc;
        r_otag    <= n_otag;
        r_olast   <= n_olast;
    end

    // outputs
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_entry_count   = r_ocnt;
    assign o_head_start_pc = r_ohs;
    assign o_head_end_pc   = r_ohe;
    assign o_head_ops      = r_ohops;
    assign o_out_slot      = r_oslot;
    assign o_out_pc        = r_opc;
    assign o_out_tag       = r_otag;
    assign o_last          = r_olast;

endmodule

>>> design/ftqpf_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ftqpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
